// ----- design/tplru_pkg.sv -----
// ----------------------------------------------------------------------------
// tplru_pkg
// Shared types and constants for the tree pseudo-LRU tag lookup block.
// ----------------------------------------------------------------------------
package tplru_pkg;

    // fixed field widths of the access and result words
    localparam int SET_IN_W   = 6;
    localparam int TAG_IN_W   = 20;
    localparam int OUT_WAY_W  = 3;
    localparam int OUT_LINE_W = 9;
    localparam int CNT_W      = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch the access word, launch the set read
        logic update;   // compare, write back, load the result
        logic clear;    // zero one metadata row
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last; // clearing pass is on its final row
    } t_sts;

endpackage

// ----- design/tree_plru_cache_lookup.sv -----
// Flow: a word taken with start has its set read through the registered RAM port,
// then is compared and written back as the result registers load; o_done marks
// the result for one cycle. A new word is taken only after the read-modify-write
// of the per-set tag row and PLRU/fill word, with o_busy high during the update.
// Reset: counters clear at once; a clearing pass then zeroes the PLRU and fill
// words, one set a cycle, with o_busy high throughout.
// ----------------------------------------------------------------------------
// tree_plru_cache_lookup
// Set-associative tag lookup with in-order fill and tree pseudo-LRU
// replacement, reporting hit, way, line and running hit and miss totals.
// ----------------------------------------------------------------------------
module tree_plru_cache_lookup #(
    parameter int WAYS      = 8,
    parameter int SETS      = 64,
    parameter int TAG_WIDTH = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [tplru_pkg::SET_IN_W-1:0]       i_set_index,
    input  logic [tplru_pkg::TAG_IN_W-1:0]       i_tag,
    output logic                                 o_busy,
    output logic                                 o_done,
    output logic                                 o_hit,
    output logic [tplru_pkg::OUT_WAY_W-1:0]      o_way,
    output logic [tplru_pkg::OUT_LINE_W-1:0]     o_line,
    output logic [tplru_pkg::CNT_W-1:0]          o_hit_total,
    output logic [tplru_pkg::CNT_W-1:0]          o_miss_total
);

    tplru_pkg::t_cmd cmd;
    tplru_pkg::t_sts sts;

    tplru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    tplru_dp #(
        .WAYS      (WAYS),
        .SETS      (SETS),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_set_index  (i_set_index),
        .i_tag        (i_tag),
        .o_hit        (o_hit),
        .o_way        (o_way),
        .o_line       (o_line),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total)
    );

    // a result word only follows an update cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result strobe without a preceding update");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_hit_keeps_misses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> (o_miss_total == $past(o_miss_total)))
        else $error("miss total moved on a hit");

    a_miss_keeps_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_hit_total == $past(o_hit_total)))
        else $error("hit total moved on a miss");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> (!cmd.update && !cmd.load))
        else $error("access issued during the clearing pass");

endmodule

// ----- design/tplru_ram.sv -----
// ----------------------------------------------------------------------------
// tplru_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tplru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/tplru_ctrl.sv -----
// ----------------------------------------------------------------------------
// tplru_ctrl
// Sequencer: clearing pass after reset, then a two-step read / update
// cycle for each access word.
// ----------------------------------------------------------------------------
module tplru_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tplru_pkg::t_sts  i_sts,
    output tplru_pkg::t_cmd  o_cmd,
    output logic             o_busy,
    output logic             o_done
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd.load   = (r_state == ST_IDLE) && i_start;
        o_cmd.update = (r_state == ST_LOOK);
        o_cmd.clear  = (r_state == ST_CLEAR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_LOOK);
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

// ----- design/tplru_dp.sv -----
// ----------------------------------------------------------------------------
// tplru_dp
// Tag and metadata stores, parallel tag compare, PLRU tree update and
// victim walk, hit and miss counters, result registers.
// ----------------------------------------------------------------------------
module tplru_dp #(
    parameter int WAYS      = 8,
    parameter int SETS      = 64,
    parameter int TAG_WIDTH = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tplru_pkg::t_cmd                      i_cmd,
    output tplru_pkg::t_sts                      o_sts,
    input  logic [tplru_pkg::SET_IN_W-1:0]       i_set_index,
    input  logic [tplru_pkg::TAG_IN_W-1:0]       i_tag,
    output logic                                 o_hit,
    output logic [tplru_pkg::OUT_WAY_W-1:0]      o_way,
    output logic [tplru_pkg::OUT_LINE_W-1:0]     o_line,
    output logic [tplru_pkg::CNT_W-1:0]          o_hit_total,
    output logic [tplru_pkg::CNT_W-1:0]          o_miss_total
);

    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = $clog2(WAYS);
    localparam int FILL_W  = $clog2(WAYS + 1);
    localparam int TREE_N  = WAYS - 1;
    localparam int NODE_W  = (WAYS > 2) ? $clog2(WAYS - 1) : 1;
    localparam int LV      = $clog2(WAYS + 1) - 1;   // floor(log2(WAYS))
    localparam int HW_W    = WAY_W + 2;
    localparam int META_W  = FILL_W + TREE_N;
    localparam int ROW_W   = WAYS * TAG_WIDTH;
    localparam int PROD_W  = SET_W + WAY_W + 1;
    localparam int LUT_N   = 2 ** tplru_pkg::SET_IN_W;

    // set index reduced modulo SETS, worked out at elaboration
    logic [SET_W-1:0] set_lut [LUT_N];
    for (genvar g = 0; g < LUT_N; g++) begin : g_lut
        assign set_lut[g] = SET_W'(g % SETS);
    end

    logic [SET_W-1:0]     r_set;
    logic [TAG_WIDTH-1:0] r_tag;
    logic [SET_W-1:0]     r_clr_addr;
    logic [SET_W-1:0]     rd_set;

    logic [META_W-1:0]    meta_rd;
    logic [META_W-1:0]    meta_wr;
    logic [SET_W-1:0]     meta_waddr;
    logic                 meta_we;
    logic [ROW_W-1:0]     row_rd;
    logic [ROW_W-1:0]     row_wr;
    logic                 row_we;

    logic [FILL_W-1:0]    fill;
    logic [TREE_N-1:0]    tree;
    logic                 hit;
    logic [WAY_W-1:0]     hit_way;
    logic                 full;
    logic [WAY_W-1:0]     touch_way;
    logic [TREE_N-1:0]    touch_tree;
    logic [WAY_W-1:0]     vic_way;
    logic [TREE_N-1:0]    vic_tree;
    logic [WAY_W-1:0]     sel_way;
    logic [TREE_N-1:0]    new_tree;
    logic [FILL_W-1:0]    new_fill;
    logic [PROD_W-1:0]    line_full;

    logic                                r_hit;
    logic [tplru_pkg::OUT_WAY_W-1:0]     r_way;
    logic [tplru_pkg::OUT_LINE_W-1:0]    r_line;
    logic [tplru_pkg::CNT_W-1:0]         r_hits;
    logic [tplru_pkg::CNT_W-1:0]         r_misses;

    assign rd_set = set_lut[i_set_index];

    tplru_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wr),
        .i_re    (i_cmd.load),
        .i_raddr (rd_set),
        .o_rdata (meta_rd)
    );

    tplru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_set),
        .i_wdata (row_wr),
        .i_re    (i_cmd.load),
        .i_raddr (rd_set),
        .o_rdata (row_rd)
    );

    assign fill = meta_rd[META_W-1 -: FILL_W];
    assign tree = meta_rd[TREE_N-1:0];
    assign full = (fill >= FILL_W'(WAYS));

    // ways fill in order and are never dropped, so way i is valid when i < fill
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if ((FILL_W'(i) < fill) && (row_rd[i*TAG_WIDTH +: TAG_WIDTH] == r_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
        end
    end

    assign touch_way = hit ? hit_way : WAY_W'(fill);

    // mark the path to touch_way, halving [0, WAYS) at each level
    always_comb begin
        logic [HW_W-1:0]   lo;
        logic [HW_W-1:0]   hi;
        logic [HW_W-1:0]   mid;
        logic [NODE_W-1:0] node;
        touch_tree = tree;
        lo         = '0;
        hi         = HW_W'(WAYS);
        node       = '0;
        for (int k = 0; k < LV; k++) begin
            mid = (lo + hi) >> 1;
            if (HW_W'(touch_way) < mid) begin
                touch_tree[node] = 1'b0;
                hi               = mid;
                node             = NODE_W'(2 * node + 1);
            end else begin
                touch_tree[node] = 1'b1;
                lo               = mid;
                node             = NODE_W'(2 * node + 2);
            end
        end
    end

    // victim walk: 0 sends right, 1 sends left, each bit passed flips
    always_comb begin
        logic [NODE_W-1:0] node;
        vic_tree = tree;
        vic_way  = '0;
        node     = '0;
        for (int k = 0; k < LV; k++) begin
            if (!vic_tree[node]) begin
                vic_tree[node]      = 1'b1;
                vic_way[LV - k - 1] = 1'b1;
                node                = NODE_W'(2 * node + 2);
            end else begin
                vic_tree[node] = 1'b0;
                node           = NODE_W'(2 * node + 1);
            end
        end
    end

    always_comb begin
        if (!hit && full) begin
            sel_way  = vic_way;
            new_tree = vic_tree;
            new_fill = fill;
        end else begin
            sel_way  = touch_way;
            new_tree = touch_tree;
            new_fill = hit ? fill : (fill + FILL_W'(1));
        end
    end

    always_comb begin
        row_wr = row_rd;
        for (int i = 0; i < WAYS; i++) begin
            if (sel_way == WAY_W'(i)) begin
                row_wr[i*TAG_WIDTH +: TAG_WIDTH] = r_tag;
            end
        end
    end

    assign row_we     = i_cmd.update && !hit;
    assign meta_we    = i_cmd.update || i_cmd.clear;
    assign meta_waddr = i_cmd.clear ? r_clr_addr : r_set;
    assign meta_wr    = i_cmd.clear ? '0 : {new_fill, new_tree};

    assign line_full = PROD_W'(r_set) * PROD_W'(WAYS) + PROD_W'(sel_way);

    assign o_sts.clr_last = (r_clr_addr == SET_W'(SETS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_hits     <= '0;
            r_misses   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + SET_W'(1);
            end
            if (i_cmd.update) begin
                if (hit) begin
                    if (r_hits != tplru_pkg::CNT_MAX) begin
                        r_hits <= r_hits + tplru_pkg::CNT_W'(1);
                    end
                end else if (r_misses != tplru_pkg::CNT_MAX) begin
                    r_misses <= r_misses + tplru_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set <= rd_set;
            r_tag <= TAG_WIDTH'(i_tag);
        end
        if (i_cmd.update) begin
            r_hit  <= hit;
            r_way  <= tplru_pkg::OUT_WAY_W'(sel_way);
            r_line <= tplru_pkg::OUT_LINE_W'(line_full);
        end
    end

    assign o_hit        = r_hit;
    assign o_way        = r_way;
    assign o_line       = r_line;
    assign o_hit_total  = r_hits;
    assign o_miss_total = r_misses;

endmodule

// ----- verif/tb_tree_plru_cache_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tree_plru_cache_lookup
// Self-checking bench for the tree pseudo-LRU tag lookup. A queue-fed driver
// issues access words on the start/busy handshake. A local model of the tag
// store, fill counts and PLRU trees predicts every result, and a monitor
// compares each o_done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_tree_plru_cache_lookup;

    localparam int N_WAYS      = 8;
    localparam int N_SETS      = 64;
    localparam int N_TAG_W     = 20;
    localparam int TREE_LEVELS = 3;
    localparam int POOL_DEPTH  = 12;
    localparam int PHASE_WORDS = 600;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [tplru_pkg::SET_IN_W-1:0] set_index;
        logic [tplru_pkg::TAG_IN_W-1:0] tag;
    } t_access;

    typedef struct {
        logic                             hit;
        logic [tplru_pkg::OUT_WAY_W-1:0]  way;
        logic [tplru_pkg::OUT_LINE_W-1:0] line;
        logic [tplru_pkg::CNT_W-1:0]      hit_total;
        logic [tplru_pkg::CNT_W-1:0]      miss_total;
    } t_lookup_res;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_start;
    logic [tplru_pkg::SET_IN_W-1:0]   i_set_index;
    logic [tplru_pkg::TAG_IN_W-1:0]   i_tag;
    logic                             o_busy;
    logic                             o_done;
    logic                             o_hit;
    logic [tplru_pkg::OUT_WAY_W-1:0]  o_way;
    logic [tplru_pkg::OUT_LINE_W-1:0] o_line;
    logic [tplru_pkg::CNT_W-1:0]      o_hit_total;
    logic [tplru_pkg::CNT_W-1:0]      o_miss_total;

    // model state
    logic [N_TAG_W-1:0]             tag_mem   [N_SETS*N_WAYS];
    bit                             valid_mem [N_SETS*N_WAYS];
    int unsigned                    fill_mem  [N_SETS];
    logic [N_WAYS-2:0]              tree_mem  [N_SETS];
    logic [tplru_pkg::CNT_W-1:0]    hits_seen;
    logic [tplru_pkg::CNT_W-1:0]    misses_seen;

    t_access                        access_q [$];
    t_lookup_res                    result_q [$];
    logic [tplru_pkg::TAG_IN_W-1:0] tag_pool [N_SETS][POOL_DEPTH];

    int unsigned                    idle_pct;
    int unsigned                    err_cnt;
    int unsigned                    cycle_cnt;
    bit                             send_now;
    t_lookup_res                    exp_res;

    tree_plru_cache_lookup #(
        .WAYS      (N_WAYS),
        .SETS      (N_SETS),
        .TAG_WIDTH (N_TAG_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_set_index  (i_set_index),
        .i_tag        (i_tag),
        .o_busy       (o_busy),
        .o_done       (o_done),
        .o_hit        (o_hit),
        .o_way        (o_way),
        .o_line       (o_line),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mark the path to a way as most recently used
    function automatic logic [N_WAYS-2:0] touch_tree(input logic [N_WAYS-2:0] tree,
                                                     input int way);
        int lo;
        int hi;
        int mid;
        int node;
        lo   = 0;
        hi   = N_WAYS;
        node = 0;
        for (int k = 0; k < TREE_LEVELS; k++) begin
            mid = (lo + hi) / 2;
            if (way < mid) begin
                tree[node] = 1'b0;
                hi         = mid;
                node       = 2 * node + 1;
            end else begin
                tree[node] = 1'b1;
                lo         = mid;
                node       = 2 * node + 2;
            end
        end
        return tree;
    endfunction

    function automatic t_lookup_res predict_lookup(
        input logic [tplru_pkg::SET_IN_W-1:0] set_i,
        input logic [tplru_pkg::TAG_IN_W-1:0] tag_i
    );
        int                base;
        int                way;
        int                node;
        bit                found;
        logic [N_WAYS-2:0] tree;
        t_lookup_res       res;
        base  = int'(set_i) * N_WAYS;
        way   = 0;
        found = 1'b0;
        for (int i = 0; i < N_WAYS; i++) begin
            if (!found && valid_mem[base+i] && tag_mem[base+i] == tag_i) begin
                found = 1'b1;
                way   = i;
            end
        end
        tree = tree_mem[set_i];
        if (found) begin
            if (hits_seen != tplru_pkg::CNT_MAX) hits_seen = hits_seen + 1;
            tree = touch_tree(tree, way);
        end else begin
            if (misses_seen != tplru_pkg::CNT_MAX) misses_seen = misses_seen + 1;
            if (fill_mem[set_i] >= N_WAYS) begin
                // full set: follow the tree to the victim, flipping every bit passed
                node = 0;
                for (int k = 0; k < TREE_LEVELS; k++) begin
                    if (tree[node] == 1'b0) begin
                        tree[node] = 1'b1;
                        way        = way | (1 << (TREE_LEVELS - 1 - k));
                        node       = 2 * node + 2;
                    end else begin
                        tree[node] = 1'b0;
                        node       = 2 * node + 1;
                    end
                end
            end else begin
                way             = int'(fill_mem[set_i]);
                fill_mem[set_i] = fill_mem[set_i] + 1;
                tree            = touch_tree(tree, way);
            end
            valid_mem[base+way] = 1'b1;
            tag_mem[base+way]   = tag_i;
        end
        tree_mem[set_i] = tree;
        res.hit        = found;
        res.way        = tplru_pkg::OUT_WAY_W'(way);
        res.line       = tplru_pkg::OUT_LINE_W'(base + way);
        res.hit_total  = hits_seen;
        res.miss_total = misses_seen;
        return res;
    endfunction

    // driver: one word per accepted handshake, random gaps per idle_pct
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) begin
            result_q.insert(result_q.size(), predict_lookup(i_set_index, i_tag));
            access_q.delete(0);
        end
        send_now = i_rst_n && (access_q.size() != 0) && ($urandom_range(99, 0) >= idle_pct);
        if (send_now) begin
            i_start     <= 1'b1;
            i_set_index <= access_q[0].set_index;
            i_tag       <= access_q[0].tag;
        end else begin
            i_start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (result_q.size() == 0) begin
                if (err_cnt < 10)
                    $display("unexpected result: hit=%0d way=%0d line=%0d hits=%0d misses=%0d",
                             o_hit, o_way, o_line, o_hit_total, o_miss_total);
                err_cnt++;
            end else begin
                exp_res = result_q.pop_front();
                if (o_hit !== exp_res.hit || o_way !== exp_res.way || o_line !== exp_res.line
                    || o_hit_total !== exp_res.hit_total
                    || o_miss_total !== exp_res.miss_total) begin
                    if (err_cnt < 10) begin
                        $display("mismatch exp: hit=%0d way=%0d line=%0d hits=%0d misses=%0d",
                                 exp_res.hit, exp_res.way, exp_res.line,
                                 exp_res.hit_total, exp_res.miss_total);
                        $display("         got: hit=%0d way=%0d line=%0d hits=%0d misses=%0d",
                                 o_hit, o_way, o_line, o_hit_total, o_miss_total);
                    end
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_access(input int set_i, input logic [tplru_pkg::TAG_IN_W-1:0] tag_i);
        t_access acc;
        acc.set_index = tplru_pkg::SET_IN_W'(set_i);
        acc.tag       = tag_i;
        access_q.insert(access_q.size(), acc);
    endtask

    // mostly pooled tags on a few busy sets, so sets fill and start replacing
    task automatic add_random(input int count);
        int set_i;
        for (int n = 0; n < count; n++) begin
            set_i = ($urandom_range(99, 0) < 60) ? $urandom_range(7, 0) : $urandom_range(63, 0);
            if ($urandom_range(99, 0) < 80)
                add_access(set_i, tag_pool[set_i][$urandom_range(POOL_DEPTH - 1, 0)]);
            else
                add_access(set_i, tplru_pkg::TAG_IN_W'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (access_q.size() != 0 || i_start) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_set_index = '0;
        i_tag       = '0;
        idle_pct    = 0;
        err_cnt     = 0;
        cycle_cnt   = 0;
        hits_seen   = '0;
        misses_seen = '0;
        for (int i = 0; i < N_SETS * N_WAYS; i++) begin
            tag_mem[i]   = '0;
            valid_mem[i] = 1'b0;
        end
        for (int s = 0; s < N_SETS; s++) begin
            fill_mem[s] = 0;
            tree_mem[s] = '0;
            for (int p = 0; p < POOL_DEPTH; p++)
                tag_pool[s][p] = tplru_pkg::TAG_IN_W'($urandom);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extreme tags on the lowest set, then the same tag in another set
        add_access(0, '0);
        add_access(0, '1);
        add_access(0, '0);
        add_access(0, '1);
        add_access(1, '0);
        // fill the top set in order, then replace through the tree
        for (int w = 0; w < N_WAYS; w++) add_access(63, tplru_pkg::TAG_IN_W'(20'h00010 + w));
        add_access(63, tplru_pkg::TAG_IN_W'(20'h00013));
        add_access(63, '1);
        add_access(63, '0);
        add_access(63, tplru_pkg::TAG_IN_W'(20'h00010));
        add_access(63, tplru_pkg::TAG_IN_W'(20'h00017));
        add_access(63, tplru_pkg::TAG_IN_W'(20'hABCDE));
        wait_drained();

        idle_pct = 7;
        add_random(PHASE_WORDS);
        wait_drained();
        idle_pct = 57;
        add_random(PHASE_WORDS);
        wait_drained();
        idle_pct = 0;
        add_random(PHASE_WORDS);
        wait_drained();

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
